### rtl/core/rmh_pkg.sv
// rmh_pkg: shared types and constants for the two-heap running median block
// no dependencies
`default_nettype none
package rmh_pkg;

	localparam int HEAP_DEPTH_DEF   = 512;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int SUM_W            = 16;
	localparam logic [SUM_W-1:0] MODULUS_RST = 16'd10000;

	localparam logic HEAP_LO = 1'b0;
	localparam logic HEAP_HI = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP,
		S_UP_CMP,
		S_BAL,
		S_POP,
		S_POP_LAST,
		S_DN,
		S_DN_SEL,
		S_DN_CMP,
		S_PUSH2,
		S_SUM,
		S_MOD,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

### rtl/core/running_median_two_heap.sv
// running_median_two_heap: top level, sequencer around two heap memories
// depends on rmh_pkg and rmh_heap_mem
`default_nettype none
// Each sample request is inserted into a max-heap (lower half) or a min-heap
// (upper half), the heaps are rebalanced, and the lower median plus the
// running sum of medians modulo cfg_data are returned. A sift-up level
// costs a parent read and a compare-write, a sift-down level a read of both
// children, a child select and a compare-write, all through the single
// shared comparator. The modulo is a restoring reduction of the 17-bit sum,
// one bit per cycle. A sample aimed at a full heap is dropped with status 1.
// No clearing pass follows reset.
module running_median_two_heap #(
	parameter int HEAP_DEPTH   = rmh_pkg::HEAP_DEPTH_DEF,
	parameter int SAMPLE_WIDTH = rmh_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	// sample
	input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic      m_axis_tvalid,
	input  wire logic m_axis_tready,
	// median, median_sum, status
	output logic [((SAMPLE_WIDTH+rmh_pkg::SUM_W+1+7)/8)*8-1:0] m_axis_tdata,
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic [rmh_pkg::SUM_W-1:0] cfg_data
);
	import rmh_pkg::*;

	localparam int W    = SAMPLE_WIDTH;
	localparam int AW   = (HEAP_DEPTH > 2) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CW   = $clog2(HEAP_DEPTH + 1);
	localparam int SW   = ((W > SUM_W) ? W : SUM_W) + 1;
	localparam int KW   = $clog2(SW);
	localparam int OW   = ((W + SUM_W + 1 + 7) / 8) * 8;
	localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);

	state_t state_q, state_d;

	logic [CW-1:0]    cnt_q [2];
	logic [W-1:0]     top_q [2];
	logic             sel_q;
	logic             phase_q;
	logic             drop_q;
	logic [AW-1:0]    pos_q;
	logic [W-1:0]     val_q;
	logic [W-1:0]     pop_val_q;
	logic [W-1:0]     last_q;
	logic [W-1:0]     cand_q;
	logic [AW-1:0]    cpos_q;
	logic [SW-1:0]    rem_q;
	logic [KW-1:0]    k_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] modulus_q;
	logic [W-1:0]     omed_q;
	logic [SUM_W-1:0] osum_q;
	logic             ostat_q;
	logic             ovalid_q;

	logic          we;
	logic [AW-1:0] wa, ra, rb;
	logic [W-1:0]  wd;
	logic [W-1:0]  rd_a [2];
	logic [W-1:0]  rd_b [2];
	logic [W-1:0]  ra_d, rb_d;

	logic [W-1:0]  sample;
	logic          s_acc;
	logic          to_lower;
	logic          full;
	logic [W-1:0]  med;
	logic [CW:0]   child;
	logic [CW-1:0] n_cur;
	logic [W-1:0]  cmp_a, cmp_b;
	logic          ranks;
	logic [SW-1:0] mod_ext;
	logic          sub_ok;
	logic          out_free;

	assign sample   = s_axis_tdata[W-1:0];
	assign s_acc    = s_axis_tvalid && s_axis_tready;
	assign to_lower = (cnt_q[HEAP_LO] == '0) || (sample < top_q[HEAP_LO]);
	assign full     = to_lower ? (cnt_q[HEAP_LO] >= DEPTH_C) : (cnt_q[HEAP_HI] >= DEPTH_C);
	assign out_free = !ovalid_q || m_axis_tready;
	assign ra_d     = rd_a[sel_q];
	assign rb_d     = rd_b[sel_q];
	assign n_cur    = cnt_q[sel_q];
	assign child    = {{(CW - AW){1'b0}}, pos_q, 1'b1};
	assign mod_ext  = SW'({(modulus_q == '0), modulus_q});
	assign sub_ok   = (rem_q >> k_q) >= mod_ext;

	always_comb begin
		if (cnt_q[HEAP_HI] > cnt_q[HEAP_LO]) begin
			med = top_q[HEAP_HI];
		end else if (cnt_q[HEAP_LO] != '0) begin
			med = top_q[HEAP_LO];
		end else begin
			med = '0;
		end
	end

	// shared comparator
	always_comb begin
		case (state_q)
			S_DN_SEL: begin
				cmp_a = rb_d;
				cmp_b = ra_d;
			end
			S_DN_CMP: begin
				cmp_a = cand_q;
				cmp_b = last_q;
			end
			default: begin
				cmp_a = val_q;
				cmp_b = ra_d;
			end
		endcase
		ranks = (sel_q == HEAP_LO) ? (cmp_a > cmp_b) : (cmp_a < cmp_b);
	end

	for (genvar h = 0; h < 2; h++) begin : g_heap
		rmh_heap_mem #(
			.DEPTH(HEAP_DEPTH),
			.AW   (AW),
			.W    (W)
		) u_mem (
			.clk (clk),
			.we  (we && (sel_q == 1'(h))),
			.wa  (wa),
			.wd  (wd),
			.ra  (ra),
			.rb  (rb),
			.rd_a(rd_a[h]),
			.rd_b(rd_b[h])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		wa      = pos_q;
		wd      = val_q;
		ra      = pos_q;
		rb      = pos_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					state_d = full ? S_DONE : S_UP;
				end
			end
			S_UP: begin
				if (pos_q == '0) begin
					we      = 1'b1;
					state_d = S_BAL;
				end else begin
					ra      = (pos_q - AW'(1)) >> 1;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (ranks) begin
					wd      = ra_d;
					state_d = S_UP;
				end else begin
					state_d = S_BAL;
				end
			end
			S_BAL: begin
				if (phase_q) begin
					state_d = S_SUM;
				end else if (cnt_q[HEAP_HI] > cnt_q[HEAP_LO] + CW'(1)
					|| cnt_q[HEAP_LO] > cnt_q[HEAP_HI] + CW'(1)) begin
					state_d = S_POP;
				end else begin
					state_d = S_SUM;
				end
			end
			S_POP: begin
				ra      = AW'(n_cur - CW'(1));
				state_d = (n_cur == CW'(1)) ? S_PUSH2 : S_POP_LAST;
			end
			S_POP_LAST: begin
				state_d = S_DN;
			end
			S_DN: begin
				if (child >= {1'b0, n_cur}) begin
					we      = 1'b1;
					wd      = last_q;
					state_d = S_PUSH2;
				end else begin
					ra      = AW'(child);
					rb      = AW'(child + (CW + 1)'(1));
					state_d = S_DN_SEL;
				end
			end
			S_DN_SEL: begin
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (ranks) begin
					wd      = cand_q;
					state_d = S_DN;
				end else begin
					wd      = last_q;
					state_d = S_PUSH2;
				end
			end
			S_PUSH2: begin
				state_d = S_UP;
			end
			S_SUM: begin
				state_d = S_MOD;
			end
			S_MOD: begin
				if (k_q == '0) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q[HEAP_LO] <= '0;
			cnt_q[HEAP_HI] <= '0;
			sum_q          <= '0;
			modulus_q      <= MODULUS_RST;
			ovalid_q       <= 1'b0;
			phase_q        <= 1'b0;
			drop_q         <= 1'b0;
		end else begin
			if (cfg_valid) begin
				modulus_q <= cfg_data;
			end
			if (state_q == S_DONE && out_free) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						drop_q  <= full;
						phase_q <= 1'b0;
						if (!full) begin
							if (to_lower) begin
								cnt_q[HEAP_LO] <= cnt_q[HEAP_LO] + CW'(1);
							end else begin
								cnt_q[HEAP_HI] <= cnt_q[HEAP_HI] + CW'(1);
							end
						end
					end
				end
				S_POP: begin
					cnt_q[sel_q] <= n_cur - CW'(1);
				end
				S_PUSH2: begin
					phase_q       <= 1'b1;
					cnt_q[!sel_q] <= cnt_q[!sel_q] + CW'(1);
				end
				S_MOD: begin
					if (k_q == '0) begin
						sum_q <= sub_ok ? SUM_W'(rem_q - mod_ext) : SUM_W'(rem_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (we && wa == '0) begin
			top_q[sel_q] <= wd;
		end
		case (state_q)
			S_IDLE: begin
				val_q <= sample;
				sel_q <= to_lower ? HEAP_LO : HEAP_HI;
				pos_q <= to_lower ? AW'(cnt_q[HEAP_LO]) : AW'(cnt_q[HEAP_HI]);
			end
			S_UP: begin
				if (pos_q != '0) begin
					cpos_q <= (pos_q - AW'(1)) >> 1;
				end
			end
			S_UP_CMP: begin
				pos_q <= cpos_q;
			end
			S_BAL: begin
				sel_q <= (cnt_q[HEAP_HI] > cnt_q[HEAP_LO]) ? HEAP_HI : HEAP_LO;
			end
			S_POP: begin
				pop_val_q <= top_q[sel_q];
				pos_q     <= '0;
			end
			S_POP_LAST: begin
				last_q <= ra_d;
			end
			S_DN_SEL: begin
				if ((child + (CW + 1)'(1)) < {1'b0, n_cur} && ranks) begin
					cand_q <= rb_d;
					cpos_q <= AW'(child + (CW + 1)'(1));
				end else begin
					cand_q <= ra_d;
					cpos_q <= AW'(child);
				end
			end
			S_DN_CMP: begin
				pos_q <= cpos_q;
			end
			S_PUSH2: begin
				val_q <= pop_val_q;
				sel_q <= !sel_q;
				pos_q <= AW'(cnt_q[!sel_q]);
			end
			S_SUM: begin
				rem_q <= SW'(sum_q) + SW'(med);
				k_q   <= KW'(SW - 1);
			end
			S_MOD: begin
				if (sub_ok) begin
					rem_q <= rem_q - (mod_ext << k_q);
				end
				k_q <= k_q - KW'(1);
			end
			S_DONE: begin
				if (out_free) begin
					omed_q  <= med;
					osum_q  <= sum_q;
					ostat_q <= drop_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = OW'({ostat_q, osum_q, omed_q});

`ifndef SYNTHESIS
	a_balanced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> (cnt_q[HEAP_LO] <= cnt_q[HEAP_HI] + CW'(1)
			&& cnt_q[HEAP_HI] <= cnt_q[HEAP_LO] + CW'(1)))
		else $error("heap sizes out of balance");
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[HEAP_LO] <= DEPTH_C && cnt_q[HEAP_HI] <= DEPTH_C)
		else $error("heap count beyond depth");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_axis_tready)
		else $error("request taken while busy");
`endif
endmodule
`default_nettype wire

### rtl/core/rmh_heap_mem.sv
// rmh_heap_mem: heap storage, one write port and two registered read ports
// depends on nothing
`default_nettype none
module rmh_heap_mem #(
	parameter int DEPTH = 512,
	parameter int AW    = 9,
	parameter int W     = 16
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] wa,
	input  wire logic [W-1:0]  wd,
	input  wire logic [AW-1:0] ra,
	input  wire logic [AW-1:0] rb,
	output logic      [W-1:0]  rd_a,
	output logic      [W-1:0]  rd_b
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_a <= mem[ra];
		rd_b <= mem[rb];
	end
endmodule
`default_nettype wire
